// ----- rtl/confusion_matrix_accumulator_macros.svh -----
// Assertion macros for the confusion matrix accumulator checker
`ifndef CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH

// clocked assertion, off while reset is held
`define CMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CMA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cma_pkg.sv -----
// Shared types and constants of the confusion matrix accumulator
package cma_pkg;

  localparam int CLASSES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int CLS_W          = 4;
  localparam int NC_W           = 5;
  localparam int Q_W            = 17;
  localparam int FIELD_W        = 32;

  localparam logic [NC_W-1:0] NC_RESET = 5'd16;
  localparam logic [Q_W-1:0]  Q16_ONE  = 17'd65536;

  localparam logic [1:0] OP_ACC = 2'd0;
  localparam logic [1:0] OP_QRY = 2'd1;
  localparam logic [1:0] OP_CLR = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef enum logic [1:0] {
    KIND_ACC,
    KIND_QRY,
    KIND_CLR,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CLS_W-1:0]   a;
    logic [CLS_W-1:0]   p;
    logic [CLS_W-1:0]   q;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ----- rtl/cma_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module cma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cma_div.sv -----
// Restoring Q1.16 ratio divider, one quotient bit per enabled cycle
module cma_div #(
  parameter int DW = 33
) (
  input  logic                 clk,
  input  logic                 start,
  input  logic                 en,
  input  logic [DW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic [cma_pkg::Q_W-1:0] quo
);
  import cma_pkg::*;

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [15:0]   q_r;
  logic          one_r;
  logic [DW:0]   two_rem;
  logic          ge;

  assign two_rem = {rem_r, 1'b0};
  assign ge      = two_rem >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
      one_r <= (den == '0) || (num >= den);
    end else if (en) begin
      rem_r <= ge ? DW'(two_rem - {1'b0, den_r}) : DW'(two_rem);
      q_r   <= {q_r[14:0], ge};
    end
  end

  assign quo = one_r ? Q16_ONE : {1'b0, q_r};

endmodule

// ----- rtl/cma_front.sv -----
// Front end: accepts beats, checks class ranges, queues classified items
module cma_front #(
  parameter int CLASSES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [cma_pkg::CLS_W-1:0]   in_actual_class,
  input  logic [cma_pkg::CLS_W-1:0]   in_predicted_class,
  input  logic [cma_pkg::CLS_W-1:0]   in_query_class,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cma_pkg::NC_W-1:0]    cfg_data,
  output logic                        hd_valid,
  output cma_pkg::item_t              hd_item,
  input  logic                        pop
);
  import cma_pkg::*;

  logic [NC_W-1:0] nc_r;
  item_t           q_mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  item_t           new_item;
  logic            push;
  logic            a_ok, p_ok, q_ok;

  function automatic logic class_ok(input logic [CLS_W-1:0] c, input logic [NC_W-1:0] nc);
    return ({1'b0, c} < nc) && ({28'd0, c} < 32'(CLASSES));
  endfunction

  assign a_ok = class_ok(in_actual_class, nc_r);
  assign p_ok = class_ok(in_predicted_class, nc_r);
  assign q_ok = class_ok(in_query_class, nc_r);

  always_comb begin
    new_item.a = in_actual_class;
    new_item.p = in_predicted_class;
    new_item.q = in_query_class;
    unique case (in_opcode)
      OP_ACC: new_item.kind = (a_ok && p_ok) ? KIND_ACC : KIND_BAD;
      OP_QRY: new_item.kind = q_ok ? KIND_QRY : KIND_BAD;
      OP_CLR: new_item.kind = KIND_CLR;
      OP_NOP: new_item.kind = KIND_BAD;
      default: new_item.kind = KIND_BAD;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign hd_valid  = (cnt_r != 2'd0);
  assign hd_item   = q_mem_r[rd_ptr_r];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r     <= NC_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        nc_r <= cfg_data;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/cma_back.sv -----
// Back end: updates counters, runs ratio dividers and drives result beats
module cma_back #(
  parameter int CLASSES    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hd_valid,
  input  cma_pkg::item_t                hd_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [cma_pkg::FIELD_W-1:0]   out_diag_count,
  output logic [cma_pkg::FIELD_W-1:0]   out_row_total,
  output logic [cma_pkg::FIELD_W-1:0]   out_col_total,
  output logic [cma_pkg::FIELD_W-1:0]   out_diag_total,
  output logic [cma_pkg::FIELD_W-1:0]   out_grand_total,
  output logic [cma_pkg::Q_W-1:0]       out_recall_q16,
  output logic [cma_pkg::Q_W-1:0]       out_precision_q16,
  output logic [cma_pkg::Q_W-1:0]       out_jaccard_q16,
  output logic [cma_pkg::Q_W-1:0]       out_accuracy_q16
);
  import cma_pkg::*;

  localparam int  CW      = $clog2(CLASSES);
  localparam int  W       = COUNT_BITS;
  localparam int  DW      = COUNT_BITS + 1;
  localparam bit  UNI_SAT = (COUNT_BITS == 64);

  back_state_t state_r, state_nxt;
  item_t       item_r;
  item_t       rd_item;
  logic [3:0]  cnt_r;
  logic [CLASSES-1:0] row_vld_r, col_vld_r, dia_vld_r;
  logic [W-1:0] diag_sum_r, total_r;
  logic [W-1:0] d_r, r_r, c_r;
  logic         r_zero_r, c_zero_r, j_one_r, st_zero_r;

  logic [CW-1:0] row_ra, col_ra, dia_ra, row_wa, col_wa;
  logic [W-1:0]  row_rd, col_rd, dia_rd;
  logic [W-1:0]  rv, cv, dv;
  logic          row_we, col_we, dia_we;
  logic          same;
  logic [W-1:0]  cmd;
  logic [DW-1:0] uni_full, uni;
  logic          div_start, div_en;
  logic [Q_W-1:0] q_rec, q_pre, q_jac, q_acc;
  logic          load_out;

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp32(input logic [W-1:0] v);
    logic [63:0] v64;
    v64 = 64'(v);
    return (|v64[63:32]) ? {FIELD_W{1'b1}} : v64[31:0];
  endfunction

  assign rd_item = (state_r == B_IDLE) ? hd_item : item_r;
  assign row_ra  = CW'((rd_item.kind == KIND_QRY) ? rd_item.q : rd_item.a);
  assign col_ra  = CW'((rd_item.kind == KIND_QRY) ? rd_item.q : rd_item.p);
  assign dia_ra  = row_ra;
  assign row_wa  = CW'(item_r.a);
  assign col_wa  = CW'(item_r.p);
  assign same    = (item_r.a == item_r.p);

  assign rv = row_vld_r[row_ra] ? row_rd : '0;
  assign cv = col_vld_r[col_ra] ? col_rd : '0;
  assign dv = dia_vld_r[dia_ra] ? dia_rd : '0;

  assign cmd      = (cv >= dv) ? cv - dv : '0;
  assign uni_full = {1'b0, rv} + {1'b0, cmd};
  assign uni      = (UNI_SAT && uni_full[W]) ? {1'b0, {W{1'b1}}} : uni_full;

  cma_ram #(.WIDTH(W), .DEPTH(CLASSES)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_wa), .wdata(sat_inc(rv)),
    .raddr(row_ra), .rdata(row_rd)
  );
  cma_ram #(.WIDTH(W), .DEPTH(CLASSES)) u_col_ram (
    .clk(clk), .we(col_we), .waddr(col_wa), .wdata(sat_inc(cv)),
    .raddr(col_ra), .rdata(col_rd)
  );
  cma_ram #(.WIDTH(W), .DEPTH(CLASSES)) u_dia_ram (
    .clk(clk), .we(dia_we), .waddr(row_wa), .wdata(sat_inc(dv)),
    .raddr(dia_ra), .rdata(dia_rd)
  );

  cma_div #(.DW(DW)) u_div_rec (
    .clk(clk), .start(div_start), .en(div_en),
    .num({1'b0, dv}), .den({1'b0, rv}), .quo(q_rec)
  );
  cma_div #(.DW(DW)) u_div_pre (
    .clk(clk), .start(div_start), .en(div_en),
    .num({1'b0, dv}), .den({1'b0, cv}), .quo(q_pre)
  );
  cma_div #(.DW(DW)) u_div_jac (
    .clk(clk), .start(div_start), .en(div_en),
    .num({1'b0, dv}), .den(uni), .quo(q_jac)
  );
  cma_div #(.DW(DW)) u_div_acc (
    .clk(clk), .start(div_start), .en(div_en),
    .num({1'b0, diag_sum_r}), .den({1'b0, total_r}), .quo(q_acc)
  );

  assign load_out = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    row_we    = 1'b0;
    col_we    = 1'b0;
    dia_we    = 1'b0;
    div_start = 1'b0;
    div_en    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (hd_valid) begin
          pop       = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        row_we    = (item_r.kind == KIND_ACC);
        col_we    = (item_r.kind == KIND_ACC);
        dia_we    = (item_r.kind == KIND_ACC) && same;
        div_start = (item_r.kind == KIND_QRY);
        state_nxt = (item_r.kind == KIND_QRY) ? B_DIV : B_DONE;
      end
      B_DIV: begin
        div_en = 1'b1;
        if (cnt_r == 4'd15) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= hd_item;
    end
    if (state_r == B_EXEC) begin
      d_r       <= dv;
      r_r       <= rv;
      c_r       <= cv;
      r_zero_r  <= (rv == '0);
      c_zero_r  <= (cv == '0);
      j_one_r   <= ({1'b0, dv} >= uni);
      st_zero_r <= (total_r == '0);
    end
    cnt_r <= div_en ? cnt_r + 4'd1 : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      col_vld_r  <= '0;
      dia_vld_r  <= '0;
      diag_sum_r <= '0;
      total_r    <= '0;
    end else if (state_r == B_EXEC) begin
      if (item_r.kind == KIND_CLR) begin
        row_vld_r  <= '0;
        col_vld_r  <= '0;
        dia_vld_r  <= '0;
        diag_sum_r <= '0;
        total_r    <= '0;
      end else if (item_r.kind == KIND_ACC) begin
        row_vld_r[row_wa] <= 1'b1;
        col_vld_r[col_wa] <= 1'b1;
        if (same) begin
          dia_vld_r[row_wa] <= 1'b1;
          diag_sum_r        <= sat_inc(diag_sum_r);
        end
        total_r <= sat_inc(total_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == B_DONE && load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_DONE && load_out) begin
      out_status        <= (item_r.kind == KIND_BAD);
      out_diag_count    <= '0;
      out_row_total     <= '0;
      out_col_total     <= '0;
      out_diag_total    <= '0;
      out_grand_total   <= '0;
      out_recall_q16    <= '0;
      out_precision_q16 <= '0;
      out_jaccard_q16   <= '0;
      out_accuracy_q16  <= '0;
      if (item_r.kind == KIND_QRY) begin
        out_diag_count    <= clamp32(d_r);
        out_row_total     <= clamp32(r_r);
        out_col_total     <= clamp32(c_r);
        out_diag_total    <= clamp32(diag_sum_r);
        out_grand_total   <= clamp32(total_r);
        out_recall_q16    <= r_zero_r ? '0 : q_rec;
        out_precision_q16 <= c_zero_r ? Q16_ONE : q_pre;
        out_jaccard_q16   <= j_one_r ? Q16_ONE : q_jac;
        out_accuracy_q16  <= st_zero_r ? '0 : q_acc;
      end
    end
  end

endmodule

// ----- rtl/confusion_matrix_accumulator.sv -----
// Top level of the confusion matrix accumulator
//
// Input channel (in_valid / in_stall): one beat per item. Opcode 0 adds one
// sample at (actual, predicted), 1 queries one class, 2 clears all counts.
// Output channel (out_valid / out_stall): exactly one result beat per item.
// Status 1 flags an out-of-range class or an unused opcode.
// Config channel (cfg_valid / cfg_ready): writes num_classes, always ready.
// An item passes from the queue through the back end's idle, execute
// and done states to the registered result beat; a query also passes
// the divide state, where the ratio dividers produce one quotient bit
// per cycle and work all four ratios in parallel. The back end runs its
// read, update and result steps on the counter RAMs for one item at a
// time and takes a new item only after the last result is loaded. A
// two-entry queue lets the front keep taking beats while the back end works.
// Reset clears every count at once and sets num_classes to 16. When the
// receiver stalls, the result beat holds and the queue fills, then
// in_stall rises.
module confusion_matrix_accumulator #(
  parameter int CLASSES    = cma_pkg::CLASSES_DEF,
  parameter int COUNT_BITS = cma_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [cma_pkg::CLS_W-1:0]   in_actual_class,
  input  logic [cma_pkg::CLS_W-1:0]   in_predicted_class,
  input  logic [cma_pkg::CLS_W-1:0]   in_query_class,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [cma_pkg::FIELD_W-1:0] out_diag_count,
  output logic [cma_pkg::FIELD_W-1:0] out_row_total,
  output logic [cma_pkg::FIELD_W-1:0] out_col_total,
  output logic [cma_pkg::FIELD_W-1:0] out_diag_total,
  output logic [cma_pkg::FIELD_W-1:0] out_grand_total,
  output logic [cma_pkg::Q_W-1:0]     out_recall_q16,
  output logic [cma_pkg::Q_W-1:0]     out_precision_q16,
  output logic [cma_pkg::Q_W-1:0]     out_jaccard_q16,
  output logic [cma_pkg::Q_W-1:0]     out_accuracy_q16,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cma_pkg::NC_W-1:0]    cfg_data
);
  import cma_pkg::*;

  logic  hd_valid;
  item_t hd_item;
  logic  pop;

  cma_front #(.CLASSES(CLASSES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_actual_class(in_actual_class), .in_predicted_class(in_predicted_class),
    .in_query_class(in_query_class),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .hd_valid(hd_valid), .hd_item(hd_item), .pop(pop)
  );

  cma_back #(.CLASSES(CLASSES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .hd_valid(hd_valid), .hd_item(hd_item), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_diag_count(out_diag_count), .out_row_total(out_row_total),
    .out_col_total(out_col_total), .out_diag_total(out_diag_total),
    .out_grand_total(out_grand_total), .out_recall_q16(out_recall_q16),
    .out_precision_q16(out_precision_q16), .out_jaccard_q16(out_jaccard_q16),
    .out_accuracy_q16(out_accuracy_q16)
  );

endmodule

// ----- rtl/cma_checker.sv -----
// Port-level checker for the confusion matrix accumulator, bound to the top
`include "confusion_matrix_accumulator_macros.svh"

module cma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [31:0] out_diag_count,
  input logic [31:0] out_grand_total,
  input logic [16:0] out_recall_q16,
  input logic [16:0] out_precision_q16,
  input logic [16:0] out_jaccard_q16,
  input logic [16:0] out_accuracy_q16
);

  `CMA_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result beat right after reset")
  `CMA_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_grand_total) && $stable(out_recall_q16), "stalled result changed")
  `CMA_ASSERT(a_ratio_range, out_valid |-> out_recall_q16 <= 17'd65536 && out_precision_q16 <= 17'd65536 && out_jaccard_q16 <= 17'd65536 && out_accuracy_q16 <= 17'd65536, "ratio above one")
  `CMA_ASSERT(a_bad_zero, out_valid && out_status |-> out_diag_count == 32'd0 && out_grand_total == 32'd0 && out_precision_q16 == 17'd0, "ignored item carries data")

endmodule

bind confusion_matrix_accumulator cma_checker u_cma_checker (.*);

// ----- verif/confusion_matrix_accumulator_tb.sv -----
// Testbench for the confusion matrix accumulator: random traffic checked against a built-in model
`timescale 1ns / 100ps

module confusion_matrix_accumulator_tb;
  import cma_pkg::*;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] actual;
    logic [3:0] predicted;
    logic [3:0] query;
  } sample_t;

  typedef struct packed {
    logic        status;
    logic [31:0] diag_count;
    logic [31:0] row_total;
    logic [31:0] col_total;
    logic [31:0] diag_total;
    logic [31:0] grand_total;
    logic [16:0] recall;
    logic [16:0] precision;
    logic [16:0] jaccard;
    logic [16:0] accuracy;
  } metrics_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_actual_class = '0;
  logic [3:0] in_predicted_class = '0;
  logic [3:0] in_query_class = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [31:0] out_diag_count, out_row_total, out_col_total, out_diag_total;
  logic [31:0] out_grand_total;
  logic [16:0] out_recall_q16, out_precision_q16, out_jaccard_q16, out_accuracy_q16;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  confusion_matrix_accumulator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [31:0] cell_cnt [256];
  logic [31:0] row_cnt [16];
  logic [31:0] col_cnt [16];
  logic [31:0] diag_cnt;
  logic [31:0] sample_cnt;
  logic [4:0] class_limit;

  sample_t pending_items[$];
  metrics_t expected_metrics[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_hold = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [16:0] q16_ratio(logic [32:0] num, logic [32:0] den);
    logic [49:0] wide;
    if (den == 0 || num >= den) return Q16_ONE;
    wide = {num, 16'd0} / den;
    return wide[16:0];
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < 256; i++) cell_cnt[i] = '0;
    for (int i = 0; i < 16; i++) begin
      row_cnt[i] = '0;
      col_cnt[i] = '0;
    end
    diag_cnt = '0;
    sample_cnt = '0;
  endfunction

  function automatic metrics_t compute_metrics(sample_t s);
    metrics_t m;
    logic [31:0] d, r, c;
    logic [32:0] uni;
    m = '0;
    case (s.opcode)
      OP_ACC: begin
        if (s.actual >= class_limit || s.predicted >= class_limit) m.status = 1'b1;
        else begin
          cell_cnt[{s.actual, s.predicted}] = sat_inc(cell_cnt[{s.actual, s.predicted}]);
          row_cnt[s.actual] = sat_inc(row_cnt[s.actual]);
          col_cnt[s.predicted] = sat_inc(col_cnt[s.predicted]);
          if (s.actual == s.predicted) diag_cnt = sat_inc(diag_cnt);
          sample_cnt = sat_inc(sample_cnt);
        end
      end
      OP_QRY: begin
        if (s.query >= class_limit) m.status = 1'b1;
        else begin
          d = cell_cnt[{s.query, s.query}];
          r = row_cnt[s.query];
          c = col_cnt[s.query];
          uni = {1'b0, r} + ((c >= d) ? {1'b0, c - d} : 33'd0);
          m.diag_count = d;
          m.row_total = r;
          m.col_total = c;
          m.diag_total = diag_cnt;
          m.grand_total = sample_cnt;
          m.recall = (r == 0) ? 17'd0 : q16_ratio(d, r);
          m.precision = (c == 0) ? Q16_ONE : q16_ratio(d, c);
          m.jaccard = ({1'b0, d} >= uni) ? Q16_ONE : q16_ratio(d, uni);
          m.accuracy = (sample_cnt == 0) ? 17'd0 : q16_ratio(diag_cnt, sample_cnt);
        end
      end
      OP_CLR: clear_counts();
      default: m.status = 1'b1;
    endcase
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("field %s: got %0d, want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    sample_t s;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid && pending_items.size() != 0)
        expected_metrics.insert(expected_metrics.size(),
                                compute_metrics(pending_items.pop_front()));
      else if (in_valid)
        report_mismatch("driver", 0, 0);
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        s = pending_items[0];
        in_valid <= 1'b1;
        in_opcode <= s.opcode;
        in_actual_class <= s.actual;
        in_predicted_class <= s.predicted;
        in_query_class <= s.query;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    metrics_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_metrics.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, 32'd0);
      end else begin
        w = expected_metrics.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_diag_count !== w.diag_count)
          report_mismatch("diag_count", out_diag_count, w.diag_count);
        if (out_row_total !== w.row_total)
          report_mismatch("row_total", out_row_total, w.row_total);
        if (out_col_total !== w.col_total)
          report_mismatch("col_total", out_col_total, w.col_total);
        if (out_diag_total !== w.diag_total)
          report_mismatch("diag_total", out_diag_total, w.diag_total);
        if (out_grand_total !== w.grand_total)
          report_mismatch("grand_total", out_grand_total, w.grand_total);
        if (out_recall_q16 !== w.recall) report_mismatch("recall", out_recall_q16, w.recall);
        if (out_precision_q16 !== w.precision)
          report_mismatch("precision", out_precision_q16, w.precision);
        if (out_jaccard_q16 !== w.jaccard)
          report_mismatch("jaccard", out_jaccard_q16, w.jaccard);
        if (out_accuracy_q16 !== w.accuracy)
          report_mismatch("accuracy", out_accuracy_q16, w.accuracy);
      end
    end
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_hold <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if (cycles > 400000) begin
      $display("confusion_matrix_accumulator: mismatch");
      $finish;
    end
  end

  function automatic sample_t make_item(logic [1:0] op, logic [3:0] a, logic [3:0] p,
                                        logic [3:0] q);
    sample_t s;
    s.opcode = op;
    s.actual = a;
    s.predicted = p;
    s.query = q;
    return s;
  endfunction

  task automatic add_item(sample_t s);
    pending_items.insert(pending_items.size(), s);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_metrics.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_classes(logic [4:0] n);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    class_limit = n;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_random_phase(int count, int top);
    sample_t s;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      s = make_item(OP_ACC, 4'($urandom_range(0, top)), 4'($urandom_range(0, top)),
                    4'($urandom_range(0, top)));
      if (k < 3) s.opcode = 2'($urandom_range(0, 3));
      else if (k < 4) s.opcode = OP_CLR;
      else if (k < 22) s.opcode = OP_QRY;
      else if (k < 26) s = 14'($urandom());
      add_item(s);
    end
  endtask

  initial begin
    clear_counts();
    class_limit = NC_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // empty matrix, all opcodes, edges of fields
    add_item(make_item(OP_QRY, 0, 0, 0));
    add_item(make_item(OP_QRY, 0, 0, 15));
    add_item(make_item(OP_ACC, 0, 0, 0));
    add_item(make_item(OP_ACC, 15, 15, 0));
    add_item(make_item(OP_ACC, 0, 15, 0));
    add_item(make_item(OP_ACC, 15, 0, 0));
    add_item(make_item(OP_ACC, 3, 5, 0));
    add_item(make_item(OP_QRY, 0, 0, 0));
    add_item(make_item(OP_QRY, 15, 15, 15));
    add_item(make_item(OP_QRY, 0, 0, 5));
    add_item(make_item(OP_QRY, 0, 0, 3));
    add_item(make_item(OP_NOP, 15, 15, 15));
    add_item(make_item(OP_CLR, 0, 0, 0));
    add_item(make_item(OP_QRY, 0, 0, 0));
    wait_idle();
    set_classes(5'd1);
    add_item(make_item(OP_ACC, 0, 1, 0));
    add_item(make_item(OP_ACC, 0, 0, 0));
    add_item(make_item(OP_QRY, 0, 0, 1));
    add_item(make_item(OP_QRY, 0, 0, 0));
    push_random_phase(150, 1);
    wait_idle();
    set_classes(5'd0);
    add_item(make_item(OP_ACC, 0, 0, 0));
    add_item(make_item(OP_QRY, 0, 0, 0));
    push_random_phase(30, 3);
    wait_idle();
    set_classes(5'd31);
    push_random_phase(500, 15);
    wait_idle();
    set_classes(5'd3);
    push_random_phase(400, 4);
    wait_idle();
    set_classes(5'd16);
    push_random_phase(300, 15);
    wait_idle();
    calm = 1'b1;
    push_random_phase(150, 7);
    wait_idle();
    if (errors == 0) $display("confusion_matrix_accumulator: match");
    else $display("confusion_matrix_accumulator: mismatch");
    $finish;
  end

endmodule

// ----- confusion_matrix_accumulator.f -----
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_ram.sv
rtl/cma_div.sv
rtl/cma_front.sv
rtl/cma_back.sv
rtl/confusion_matrix_accumulator.sv
rtl/cma_checker.sv
verif/confusion_matrix_accumulator_tb.sv
